// ===== hdl/stereo_linear_resampler_unit_macros.svh =====
// Assertion macros for the stereo linear resampler.
// Included by the top level only; no other dependencies.
`ifndef STEREO_LINEAR_RESAMPLER_UNIT_MACROS_SVH
`define STEREO_LINEAR_RESAMPLER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SLRU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slru: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define SLRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slru: next-cycle check failed");

`endif

// ===== hdl/slru_pkg.sv =====
// Shared types and constants of the stereo linear resampler.
// Used by slru_ctrl, slru_dpath and the top level; no dependencies.
package slru_pkg;

  // Outputs per input word are bounded by the minimum step of a quarter sample
  localparam int unsigned CNT_W = 3;
  localparam logic [CNT_W-1:0] MAX_RUN = 3'd4;

  // Register index of resample_step on the APB port
  localparam logic REG_STEP_IDX = 1'b0;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_EMIT
  } slru_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic ready;   // input word may be taken
    logic mul;     // form products, advance phase
    logic emit;    // load output register
    logic finish;  // close the input word, update history
  } slru_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic first;      // word restarts the phase
    logic more;       // another output lies before the current sample
    logic slot_free;  // output register can be loaded this cycle
  } slru_status_t;

endpackage

// ===== hdl/stereo_linear_resampler_unit.sv =====
// Stereo linear resampler: one input word is a signed stereo pair; each output word is the
// linear mix of the previous and current pair at a phase that advances by resample_step
// (APB register 0, 16 fraction bits, steps below a quarter are taken as a quarter). A word
// with tuser set, or the first word after reset, is passed through and restarts the phase;
// other words give zero to four outputs, the last flagged by tlast. Sequence: one word is
// handled at a time by the controller; a pass-through word goes through accept, check and
// emit, and a word giving interpolated outputs through accept and check, then one multiply
// step and one emit step per output; an emit waits while the output register holds a word
// not yet taken by m_axis_tready_i. Input is accepted while a finished word waits.
// Depends on slru_pkg, slru_ctrl, slru_dpath and the macros header.
`include "stereo_linear_resampler_unit_macros.svh"

module stereo_linear_resampler_unit import slru_pkg::*; #(
  parameter int unsigned SAMPLE_BITS     = 16,
  parameter int unsigned PHASE_FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata_i,  // left_sample, right_sample
  input  logic                 s_axis_tuser_i,                // block_start
  // output stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata_o,  // left_out, right_out
  output logic                 m_axis_tlast_o,                // last_of_run
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned SW     = PHASE_FRAC_BITS + 2;
  localparam int unsigned DATA_W = ((2*SAMPLE_BITS+7)/8)*8;

  localparam logic [SW-1:0] StepReset = {2'b01, {PHASE_FRAC_BITS{1'b0}}};

  // Configuration register
  logic [SW-1:0] step_q;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_STEP_IDX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepReset;
    end else if (cfg_wr) begin
      step_q <= pwdata[SW-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_STEP_IDX) ? 32'(step_q) : '0;

  // Controller and datapath
  slru_cmd_t    cmd;
  slru_status_t sts;

  logic signed [SB-1:0] out_left, out_right;

  assign s_axis_tready_o = cmd.ready;

  slru_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  slru_dpath #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .step_i      (step_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_left_i   ($signed(s_axis_tdata_i[SB-1:0])),
    .in_right_i  ($signed(s_axis_tdata_i[2*SB-1:SB])),
    .in_start_i  (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_left_o  (out_left),
    .out_right_o (out_right),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = DATA_W'({out_right, out_left});

  // Checks on controller and output register interplay
  `SLRU_ASSERT_NOW(a_no_emit_while_ready, clk_i, rst_ni, s_axis_tready_o, !cmd.emit)
  `SLRU_ASSERT_NOW(a_emit_into_free_slot, clk_i, rst_ni, cmd.emit, (!m_axis_tvalid_o || m_axis_tready_i))
  `SLRU_ASSERT_NEXT(a_ready_after_finish, clk_i, rst_ni, cmd.finish, s_axis_tready_o)
  `SLRU_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, (s_axis_tvalid_i && s_axis_tready_o), !s_axis_tready_o)

endmodule

// ===== hdl/slru_ctrl.sv =====
// Controller of the stereo linear resampler: sequences accept, multiply and emit.
// Depends on slru_pkg.
module slru_ctrl import slru_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  slru_status_t sts_i,
  output slru_cmd_t    cmd_o
);

  slru_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.first)     state_d = ST_EMIT;
        else if (sts_i.more) state_d = ST_MUL;
        else                 state_d = ST_IDLE;
      end
      ST_MUL: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.slot_free) begin
          if (!sts_i.first && sts_i.more) state_d = ST_MUL;
          else                            state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.ready = 1'b1;
      end
      ST_CHECK: begin
        // nothing falls inside this interval: close the word at once
        if (!sts_i.first && !sts_i.more) cmd_o.finish = 1'b1;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
      end
      ST_EMIT: begin
        if (sts_i.slot_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.finish = sts_i.first || !sts_i.more;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== hdl/slru_dpath.sv =====
// Datapath of the stereo linear resampler: history, phase, mix and output register.
// Depends on slru_pkg; driven by slru_ctrl commands.
module slru_dpath import slru_pkg::*; #(
  parameter int unsigned SAMPLE_BITS     = 16,
  parameter int unsigned PHASE_FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  slru_cmd_t                    cmd_i,
  output slru_status_t                 sts_o,
  input  logic [PHASE_FRAC_BITS+1:0]   step_i,
  input  logic                         in_valid_i,
  input  logic signed [SAMPLE_BITS-1:0] in_left_i,
  input  logic signed [SAMPLE_BITS-1:0] in_right_i,
  input  logic                         in_start_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] out_left_o,
  output logic signed [SAMPLE_BITS-1:0] out_right_o,
  output logic                         out_last_o
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned FB = PHASE_FRAC_BITS;
  localparam int unsigned SW = FB + 2;       // step width
  localparam int unsigned DW = FB + 3;       // phase distance width
  localparam int unsigned PW = SB + FB + 2;  // product and sum width
  localparam int unsigned MW = SB + FB + 5;  // full multiplier result

  localparam logic [DW-1:0] PhaseOne = {2'b00, 1'b1, {FB{1'b0}}};
  localparam logic [SW-1:0] StepMin  = {4'b0001, {(FB-2){1'b0}}};

  // History and phase
  logic signed [SB-1:0] cur_l_q, cur_r_q, prev_l_q, prev_r_q;
  logic signed [SB-1:0] prev_l_d, prev_r_d;
  logic                 start_q, have_q, have_d;
  logic [DW-1:0]        nd_q, nd_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic signed [PW-1:0] prod_l_q, prod_r_q, prod_l_d, prod_r_d;
  logic                 out_valid_q, out_valid_d;
  logic signed [SB-1:0] out_l_q, out_r_q, out_l_d, out_r_d;
  logic                 out_last_q, out_last_d;

  logic                 capture;
  logic                 first_w, more_w;
  logic [SW-1:0]        step_eff;
  logic [DW-1:0]        step_ext;

  assign capture = cmd_i.ready && in_valid_i;

  // Steps below a quarter sample are raised to a quarter
  assign step_eff = (step_i < StepMin) ? StepMin : step_i;
  assign step_ext = {1'b0, step_eff};

  assign first_w = start_q || !have_q;
  assign more_w  = (nd_q <= PhaseOne) && (cnt_q < MAX_RUN);

  assign sts_o.first     = first_w;
  assign sts_o.more      = more_w;
  assign sts_o.slot_free = !out_valid_q || out_ready_i;

  // Products t * (cur - prev), one lane per channel
  logic signed [SB:0]   diff_l, diff_r;
  logic signed [FB+3:0] t_s;
  logic signed [MW-1:0] mul_l, mul_r;

  assign diff_l   = $signed({cur_l_q[SB-1], cur_l_q}) - $signed({prev_l_q[SB-1], prev_l_q});
  assign diff_r   = $signed({cur_r_q[SB-1], cur_r_q}) - $signed({prev_r_q[SB-1], prev_r_q});
  assign t_s      = $signed({1'b0, nd_q});
  assign mul_l    = diff_l * t_s;
  assign mul_r    = diff_r * t_s;
  assign prod_l_d = mul_l[PW-1:0];
  assign prod_r_d = mul_r[PW-1:0];

  // Mix: prev * one + product, divided by one, truncated toward zero
  logic signed [PW-1:0] sum_l, sum_r, adj_l, adj_r, quo_l, quo_r;

  assign sum_l = (PW'(prev_l_q) <<< FB) + prod_l_q;
  assign sum_r = (PW'(prev_r_q) <<< FB) + prod_r_q;
  assign adj_l = sum_l + $signed({{(PW-FB){1'b0}}, {FB{sum_l[PW-1]}}});
  assign adj_r = sum_r + $signed({{(PW-FB){1'b0}}, {FB{sum_r[PW-1]}}});
  assign quo_l = adj_l >>> FB;
  assign quo_r = adj_r >>> FB;

  // Next values of state and output register
  always_comb begin
    nd_d        = nd_q;
    cnt_d       = cnt_q;
    have_d      = have_q;
    prev_l_d    = prev_l_q;
    prev_r_d    = prev_r_q;
    out_valid_d = out_valid_q;
    out_l_d     = out_l_q;
    out_r_d     = out_r_q;
    out_last_d  = out_last_q;

    if (capture) cnt_d = '0;

    if (cmd_i.mul) begin
      nd_d  = nd_q + step_ext;
      cnt_d = cnt_q + CNT_W'(1);
    end

    if (cmd_i.finish) begin
      have_d   = 1'b1;
      prev_l_d = cur_l_q;
      prev_r_d = cur_r_q;
      nd_d     = first_w ? step_ext : (nd_q - PhaseOne);
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_l_d     = first_w ? cur_l_q : quo_l[SB-1:0];
      out_r_d     = first_w ? cur_r_q : quo_r[SB-1:0];
      out_last_d  = first_w || !more_w;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nd_q        <= '0;
      cnt_q       <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      nd_q        <= nd_d;
      cnt_q       <= cnt_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (capture) begin
      cur_l_q <= in_left_i;
      cur_r_q <= in_right_i;
      start_q <= in_start_i;
    end
    if (cmd_i.mul) begin
      prod_l_q <= prod_l_d;
      prod_r_q <= prod_r_d;
    end
    prev_l_q   <= prev_l_d;
    prev_r_q   <= prev_r_d;
    out_l_q    <= out_l_d;
    out_r_q    <= out_r_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_l_q;
  assign out_right_o = out_r_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== dv/stereo_linear_resampler_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the stereo linear resampler: stereo pairs in, interpolated
// pairs out, compared word by word against a behavioural predictor held in a class.
// Depends on slru_pkg and the stereo_linear_resampler_unit top level.
module stereo_linear_resampler_unit_test;
  import slru_pkg::*;

  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned FRAC_W       = 16;
  localparam longint      PHASE_ONE    = 64'd1 << FRAC_W;
  localparam logic [17:0] STEP_FLOOR   = 18'(PHASE_ONE >> 2);
  localparam logic [17:0] STEP_UNITY   = 18'(PHASE_ONE);
  localparam logic [17:0] STEP_TOP     = 18'h3ffff;
  localparam logic [2:0]  STEP_ADDR    = 3'(4 * REG_STEP_IDX);
  localparam logic [2:0]  SPARE_ADDR   = 3'd4;
  localparam int          SETTLE_CYC   = 16;
  localparam int          HOLD_CYC     = 300;
  localparam int          PHASE_WORDS  = 80;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          REPORT_MAX   = 10;

  // One output word as it leaves the block
  typedef struct packed {
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic                last;
  } out_word_t;

  // Predictor and scoreboard: tracks history and phase, queues the words each pair causes
  class pair_resampler_model;
    logic [17:0]                step_reg;
    logic signed [SAMPLE_W-1:0] prev_l;
    logic signed [SAMPLE_W-1:0] prev_r;
    logic [18:0]                phase_dist;
    bit                         have_prev;
    out_word_t                  pending_words[$];
    int                         errors;

    function new();
      step_reg   = STEP_UNITY;
      prev_l     = '0;
      prev_r     = '0;
      phase_dist = '0;
      have_prev  = 1'b0;
      errors     = 0;
    endfunction

    function void write_reg(int idx, logic [31:0] value);
      // only the step register exists; other indexes are dropped
      if (idx == REG_STEP_IDX) step_reg = value[17:0];
    endfunction

    function int pending();
      return pending_words.size();
    endfunction

    // weighted mix of two samples at phase t, truncated toward zero
    function logic [SAMPLE_W-1:0] blend(logic signed [SAMPLE_W-1:0] a,
                                        logic signed [SAMPLE_W-1:0] b, logic [18:0] t);
      longint wa;
      longint wb;
      longint sum;
      wa  = PHASE_ONE - longint'(t);
      wb  = longint'(t);
      sum = wa * longint'(a) + wb * longint'(b);
      return SAMPLE_W'(sum / PHASE_ONE);
    endfunction

    function void note_pair(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r, logic start);
      logic [17:0] eff;
      out_word_t   w;
      int          n;
      eff = (step_reg < STEP_FLOOR) ? STEP_FLOOR : step_reg;
      n   = 0;
      if (start || !have_prev) begin
        // pass-through word restarts the phase
        w.left  = l;
        w.right = r;
        w.last  = 1'b1;
        pending_words.push_back(w);
        phase_dist = {1'b0, eff};
      end else begin
        while (phase_dist <= 19'(PHASE_ONE) && n < 4) begin
          w.left  = blend(prev_l, l, phase_dist);
          w.right = blend(prev_r, r, phase_dist);
          w.last  = 1'b0;
          pending_words.push_back(w);
          n++;
          phase_dist = phase_dist + 19'(eff);
        end
        phase_dist = phase_dist - 19'(PHASE_ONE);
        if (n > 0) pending_words[pending_words.size()-1].last = 1'b1;
      end
      prev_l    = l;
      prev_r    = r;
      have_prev = 1'b1;
    endfunction

    function void check_word(logic [31:0] data, logic last);
      out_word_t w;
      if (pending_words.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: unexpected word left=%0d right=%0d last=%0b", $realtime,
                   $signed(data[15:0]), $signed(data[31:16]), last);
      end else begin
        w = pending_words.pop_front();
        if (w.left !== data[15:0] || w.right !== data[31:16] || w.last !== last) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("%0t: mismatch exp l=%0d r=%0d last=%0b, got l=%0d r=%0d last=%0b",
                     $realtime, $signed(w.left), $signed(w.right), w.last,
                     $signed(data[15:0]), $signed(data[31:16]), last);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;   // left_sample, right_sample
  logic        s_axis_tuser_i;   // block_start
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;   // left_out, right_out
  logic        m_axis_tlast_o;   // last_of_run
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pair_resampler_model sb;
  bit                  steady_run;
  bit                  long_hold;
  int                  stall_left;
  int                  cycle_count;

  stereo_linear_resampler_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // idle lengths: mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(1, 2);
    if (r < 18) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  // sample values biased toward the extremes
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // offer one pair, optionally after an idle gap; returns at the falling edge after accept
  task automatic send_word(logic [15:0] l, logic [15:0] r, logic start);
    int gap;
    gap = (!steady_run && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {r, l};
    s_axis_tuser_i  = start;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_pair(l, r, start);
    @(negedge clk_i);
  endtask

  task automatic send_random_word();
    send_word(pick_sample(), pick_sample(), $urandom_range(0, 19) == 0);
  endtask

  // stop offering and wait until every expected word has come out
  task automatic wait_idle();
    s_axis_tvalid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // two-phase register write; the block must be idle
  task automatic reg_write(logic [2:0] addr, logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(int'(addr) / 4, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // receiver: random stalls, a long hold-off on request, none during steady runs
  initial begin
    m_axis_tready_i = 1'b0;
    stall_left      = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        m_axis_tready_i = 1'b0;
        repeat (HOLD_CYC) @(negedge clk_i);
        long_hold = 1'b0;
      end else if (steady_run) begin
        m_axis_tready_i = 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready_i = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i = 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_word(m_axis_tdata_o, m_axis_tlast_o);
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // main sequence
  initial begin
    logic [31:0] step_val;
    sb              = new();
    steady_run      = 1'b0;
    long_hold       = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset step of one sample; first word after reset has no history and passes through
    send_word(16'h8000, 16'h7fff, 1'b0);
    send_word(16'h7fff, 16'h8000, 1'b0);
    send_word(16'h0000, 16'hffff, 1'b0);
    send_word(16'hffff, 16'h0001, 1'b1);
    send_word(16'h8000, 16'h8000, 1'b0);

    // quarter step: up to four outputs per word
    wait_idle();
    reg_write(STEP_ADDR, 32'(STEP_FLOOR));
    send_word(16'h7fff, 16'h8000, 1'b0);
    send_word(16'h8000, 16'h7fff, 1'b0);
    send_word(16'h1234, 16'hedcb, 1'b1);
    send_word(16'h7fff, 16'h7fff, 1'b0);

    // step of zero is raised to a quarter
    wait_idle();
    reg_write(STEP_ADDR, 32'd0);
    send_word(16'h8000, 16'h7fff, 1'b0);
    send_word(16'h7fff, 16'h8000, 1'b0);

    // largest step: most words fall between outputs and give nothing
    wait_idle();
    reg_write(STEP_ADDR, 32'(STEP_TOP));
    repeat (5) send_word(pick_sample(), pick_sample(), 1'b0);

    // write to an address with no register must leave the step alone
    wait_idle();
    reg_write(SPARE_ADDR, 32'h0000_4000);
    repeat (2) send_word(pick_sample(), pick_sample(), 1'b0);

    // bits above the register width are dropped (leaves half a sample)
    wait_idle();
    reg_write(STEP_ADDR, 32'hfffc_8000);
    repeat (3) send_word(pick_sample(), pick_sample(), 1'b0);

    // random phases, each with its own step
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       step_val = 32'(STEP_FLOOR);
        1:       step_val = $urandom_range(16385, 131071);
        2:       step_val = 32'(STEP_UNITY);
        3:       step_val = $urandom_range(0, 16383);
        4:       step_val = 32'(STEP_TOP);
        default: step_val = $urandom_range(131072, 262143);
      endcase
      wait_idle();
      reg_write(STEP_ADDR, step_val);
      // phase 2 stalls the output for a long stretch while words keep coming
      // phase 3 runs with no idling on either side
      steady_run = (ph == 2 || ph == 3);
      if (ph == 2) long_hold = 1'b1;
      repeat (PHASE_WORDS) send_random_word();
      steady_run = 1'b0;
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/slru_pkg.sv
hdl/slru_ctrl.sv
hdl/slru_dpath.sv
hdl/stereo_linear_resampler_unit.sv
dv/stereo_linear_resampler_unit_test.sv
